/* hw/rtl/lld_pkg.sv */
// Shared types and constants for the least-loaded worker dispatcher.
`default_nettype none

package lld_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WORKERS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed field widths of the item and result channels.
    localparam int OP_W        = 2;
    localparam int ID_IN_W     = 4;
    localparam int LOAD_W      = 16;
    localparam int TOTAL_OUT_W = 5;
    localparam int LIMIT_W     = 5;

    // Configuration register map.
    localparam int                  APB_ADDR_W       = 3;
    localparam int                  APB_DATA_W       = 32;
    localparam int                  REG_IDX_W        = APB_ADDR_W - 2;
    localparam int                  REG_WORKER_LIMIT = 0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET      = 5'd7;

    // Command queue between the front and back halves.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input channel.
    typedef enum logic [OP_W-1:0] {
        OP_PICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2
    } op_t;

    // Classified command kinds handed to the back half.
    typedef enum logic [1:0] {
        CMD_PICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_BAD    = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNKNOWN   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    // Back-half sequencer states.
    typedef enum logic [1:0] {
        B_IDLE   = 2'd0,
        B_SCAN   = 2'd1,
        B_FINISH = 2'd2
    } back_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_IN_W-1:0]  worker_id;
    } cmd_t;

    typedef struct packed {
        logic [ID_IN_W-1:0]     chosen_worker;
        logic                   new_worker;
        logic [LOAD_W-1:0]      worker_load;
        logic [TOTAL_OUT_W-1:0] worker_count;
        status_t                status;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/lld_front.sv */
// Front half: accepts input transfers and classifies them into commands.
`default_nettype none

module lld_front #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [lld_pkg::OP_W-1:0]   s_operation,
    input  wire logic [lld_pkg::ID_IN_W-1:0] s_worker_id,
    output logic                            cmd_valid,
    output lld_pkg::cmd_t                   cmd,
    input  wire logic                       cmd_ready
);
    import lld_pkg::*;

    logic  hold_vld_reg;
    cmd_t  hold_cmd_reg;
    cmd_t  cls;
    logic  id_ok;

    // Decode the operation and check the worker id against the pool size.
    always_comb begin
        id_ok         = int'(s_worker_id) < MAX_WORKERS;
        cls.worker_id = s_worker_id;
        unique case (op_t'(s_operation))
            OP_PICK:       cls.kind = CMD_PICK;
            OP_REGISTER:   cls.kind = id_ok ? CMD_ADD : CMD_BAD;
            OP_UNREGISTER: cls.kind = id_ok ? CMD_REMOVE : CMD_BAD;
            default:       cls.kind = CMD_BAD;
        endcase
    end

    // One holding stage; it refills in the cycle its command moves on.
    assign s_ready   = !hold_vld_reg || cmd_ready;
    assign cmd_valid = hold_vld_reg;
    assign cmd       = hold_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (s_ready) begin
            hold_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            hold_cmd_reg <= cls;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lld_queue.sv */
// Short command queue that decouples the front and back halves.
`default_nettype none

module lld_queue (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    input  wire lld_pkg::cmd_t in_cmd,
    output logic        in_ready,
    output logic        out_valid,
    output lld_pkg::cmd_t out_cmd,
    input  wire logic   out_ready
);
    import lld_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QFILL_W-1:0]  fill_reg;
    logic                push;
    logic                pop;

    assign in_ready  = fill_reg != QFILL_W'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers wrap at the queue depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lld_back.sv */
// Back half: worker table, least-loaded scan and result register.
`default_nettype none

module lld_back #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
    parameter int COUNT_BITS  = lld_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [lld_pkg::LIMIT_W-1:0] worker_limit,
    input  wire logic                        cmd_valid,
    input  wire lld_pkg::cmd_t               cmd,
    output logic                             cmd_ready,
    output logic                             res_valid,
    output lld_pkg::res_t                    res,
    input  wire logic                        res_ready
);
    import lld_pkg::*;

    localparam int ID_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);

    back_state_t            state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [COUNT_BITS-1:0]  counts_reg [MAX_WORKERS];
    logic [ID_W-1:0]        rank_reg   [MAX_WORKERS];
    logic [ID_W-1:0]        scan_idx_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic [COUNT_BITS-1:0]  best_cnt_reg;
    logic [ID_W-1:0]        best_rank_reg;
    logic                   res_vld_reg;
    res_t                   res_reg;

    logic                   take;
    logic                   finish;
    logic                   out_free;
    logic [ID_W-1:0]        wid;
    logic [ID_W-1:0]        sel_idx;
    logic [COUNT_BITS-1:0]  sel_cnt;
    logic [ID_W-1:0]        sel_rank;
    logic                   present;
    logic                   better;
    logic                   scan_last;
    logic                   add_worker;
    logic                   do_add;
    logic                   do_change;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [ID_W-1:0]        new_id;
    res_t                   res_next;

    assign out_free  = !res_vld_reg || res_ready;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // One table read port: the scan index while scanning, else the command's worker.
    assign wid      = ID_W'(cmd_reg.worker_id);
    assign sel_idx  = (state_reg == B_SCAN) ? scan_idx_reg : wid;
    assign sel_cnt  = counts_reg[sel_idx];
    assign sel_rank = rank_reg[sel_idx];
    assign present  = CNT_W'(wid) < total_reg;
    assign new_id   = ID_W'(total_reg);

    // Lower count wins; on a tie the worker whose count changed earliest wins.
    assign better    = (scan_idx_reg == '0) || (sel_cnt < best_cnt_reg) ||
                       ((sel_cnt == best_cnt_reg) && (sel_rank < best_rank_reg));
    assign scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == total_reg;

    // A pick grows the pool when it is empty, or below the limit with all workers busy.
    assign add_worker = (total_reg == '0) ||
                        ((int'(total_reg) < int'(worker_limit)) && (best_cnt_reg != '0));

    // Sequencer: take a command, scan for picks, then finish into the result register.
    always_comb begin
        state_next = state_reg;
        take       = 1'b0;
        finish     = 1'b0;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    take       = 1'b1;
                    state_next = (cmd.kind == CMD_PICK && total_reg != '0) ? B_SCAN
                                                                           : B_FINISH;
                end
            end
            B_SCAN: begin
                if (scan_last) begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Result and table update for the command being finished.
    always_comb begin
        do_add                = 1'b0;
        do_change             = 1'b0;
        new_cnt               = sel_cnt;
        res_next.chosen_worker = cmd_reg.worker_id;
        res_next.new_worker   = 1'b0;
        res_next.worker_load  = '0;
        res_next.worker_count = TOTAL_OUT_W'(total_reg);
        res_next.status       = STAT_OK;
        case (cmd_reg.kind)
            CMD_PICK: begin
                if (add_worker && total_reg < CNT_W'(MAX_WORKERS)) begin
                    do_add                 = 1'b1;
                    res_next.chosen_worker = ID_IN_W'(total_reg);
                    res_next.new_worker    = 1'b1;
                    res_next.worker_count  = TOTAL_OUT_W'(total_reg + CNT_W'(1));
                end else begin
                    res_next.chosen_worker = ID_IN_W'(best_id_reg);
                    res_next.worker_load   = LOAD_W'(best_cnt_reg);
                end
            end
            CMD_ADD, CMD_REMOVE: begin
                if (!present) begin
                    res_next.status = STAT_UNKNOWN;
                end else if (cmd_reg.kind == CMD_ADD && (&sel_cnt)) begin
                    res_next.status      = STAT_OVERFLOW;
                    res_next.worker_load = LOAD_W'(sel_cnt);
                end else if (cmd_reg.kind == CMD_REMOVE && sel_cnt == '0) begin
                    res_next.status = STAT_UNDERFLOW;
                end else begin
                    do_change            = 1'b1;
                    new_cnt              = (cmd_reg.kind == CMD_ADD) ? sel_cnt + 1'b1
                                                                     : sel_cnt - 1'b1;
                    res_next.worker_load = LOAD_W'(new_cnt);
                end
            end
            default: begin
                res_next.status = STAT_UNKNOWN;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            total_reg   <= '0;
            res_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish && do_add) begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (finish) begin
                res_vld_reg <= 1'b1;
            end else if (res_ready) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // Command capture and running minimum of the scan.
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg      <= cmd;
            scan_idx_reg <= '0;
        end
        if (state_reg == B_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (better) begin
                best_id_reg   <= scan_idx_reg;
                best_cnt_reg  <= sel_cnt;
                best_rank_reg <= sel_rank;
            end
        end
        if (finish) begin
            res_reg <= res_next;
        end
    end

    // Worker table. Ranks hold each worker's place in the change order; a changed
    // worker moves to the tail and those behind its old place close up by one.
    always_ff @(posedge aclk) begin
        if (finish && do_add) begin
            counts_reg[new_id] <= '0;
            rank_reg[new_id]   <= new_id;
        end
        if (finish && do_change) begin
            counts_reg[wid] <= new_cnt;
            for (int j = 0; j < MAX_WORKERS; j++) begin
                if (ID_W'(j) == wid) begin
                    rank_reg[j] <= ID_W'(total_reg - CNT_W'(1));
                end else if (rank_reg[j] > sel_rank) begin
                    rank_reg[j] <= rank_reg[j] - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/least_loaded_worker_dispatch_top.sv */
// Top level of the least-loaded worker dispatcher with its configuration port.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_operation, s_worker_id
//   m_        out        m_valid / m_ready  m_chosen_worker, m_new_worker, m_worker_load,
//                                           m_worker_count, m_status
//   config    in         psel/penable/...   worker_limit at byte address 0
//
// A register or unregister goes from idle straight to the finish state in the back half;
// a pick first scans the job counts of the workers present, one worker per cycle through
// a single table read port.
// Reset clears the worker count and handshakes; no clearing pass is needed.
// A two-entry command queue lets the front keep taking transfers while the back
// half scans or waits for m_ready.
`default_nettype none

module least_loaded_worker_dispatch_top #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
    parameter int COUNT_BITS  = lld_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lld_pkg::OP_W-1:0]          s_operation,
    input  wire logic [lld_pkg::ID_IN_W-1:0]       s_worker_id,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lld_pkg::ID_IN_W-1:0]            m_chosen_worker,
    output logic                                   m_new_worker,
    output logic [lld_pkg::LOAD_W-1:0]             m_worker_load,
    output logic [lld_pkg::TOTAL_OUT_W-1:0]        m_worker_count,
    output logic [1:0]                             m_status,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lld_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lld_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lld_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import lld_pkg::*;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 limit_sel;
    logic                 front_vld;
    cmd_t                 front_cmd;
    logic                 front_rdy;
    logic                 q_vld;
    cmd_t                 q_cmd;
    logic                 q_rdy;
    res_t                 res;

    // Configuration register: written in the access phase, read back as is.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign limit_sel = reg_idx == REG_IDX_W'(REG_WORKER_LIMIT);
    assign prdata    = limit_sel ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && limit_sel) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    lld_front #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_worker_id (s_worker_id),
        .cmd_valid   (front_vld),
        .cmd         (front_cmd),
        .cmd_ready   (front_rdy)
    );

    lld_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_vld),
        .in_cmd    (front_cmd),
        .in_ready  (front_rdy),
        .out_valid (q_vld),
        .out_cmd   (q_cmd),
        .out_ready (q_rdy)
    );

    lld_back #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .worker_limit (limit_reg),
        .cmd_valid    (q_vld),
        .cmd          (q_cmd),
        .cmd_ready    (q_rdy),
        .res_valid    (m_valid),
        .res          (res),
        .res_ready    (m_ready)
    );

    // Result fields onto their own ports.
    assign m_chosen_worker = res.chosen_worker;
    assign m_new_worker    = res.new_worker;
    assign m_worker_load   = res.worker_load;
    assign m_worker_count  = res.worker_count;
    assign m_status        = res.status;

endmodule

`default_nettype wire
